/* design/tlv8_item_extractor_defines.svh */
// Assertion macros shared by the TLV8 item extractor RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef TLV8_ITEM_EXTRACTOR_DEFINES_SVH
`define TLV8_ITEM_EXTRACTOR_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define TLV8X_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expression must never be true outside reset
`define TLV8X_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define TLV8X_ASSERT(lbl, clk, rstn, prop, msg)
`define TLV8X_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

/* design/tlv8x_pkg.sv */
// Shared types and constants for the TLV8 item extractor.
// No dependencies.
package tlv8x_pkg;

	// parser position inside the TLV8 message (one-hot)
	typedef enum logic [2:0] {
		FP_TYPE  = 3'b001,
		FP_LEN   = 3'b010,
		FP_VALUE = 3'b100
	} field_phase_t;

	// progress of the merged run of the wanted type (one-hot)
	typedef enum logic [2:0] {
		MP_SEARCH = 3'b001,
		MP_RUN    = 3'b010,
		MP_DONE   = 3'b100
	} match_phase_t;

	// result pushes produced by one parsed byte
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned PTR_W      = 3;
	localparam int unsigned CNT_W      = 4;
	// occupancy at or below which a new byte may enter (two in flight, two results each)
	localparam int unsigned ROOM_MAX   = FIFO_DEPTH - 4;

endpackage

/* design/tlv8x_parser.sv */
// TLV8 byte parser: holds the message state and builds up to two results per byte.
// Depends on tlv8x_pkg.
module tlv8x_parser #(
	parameter int unsigned LENGTH_BITS = 16,
	parameter int unsigned RES_W       = LENGTH_BITS + 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               valid_s1,
	input  logic [7:0]         byte_s1,
	input  logic               last_s1,
	output tlv8x_pkg::push_t   push,
	output logic [RES_W-1:0]   res0,
	output logic [RES_W-1:0]   res1
);
	import tlv8x_pkg::*;

	logic [7:0]             wanted_q;
	field_phase_t           fp_q, fp_d;
	match_phase_t           mp_q, mp_d;
	logic [7:0]             left_q, left_d, left_dec;
	logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
	logic                   data_hit;
	logic [RES_W-1:0]       data_res, summ_res;

	// wanted type register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= '0;
		end else if (cfg_we) begin
			wanted_q <= cfg_wdata;
		end
	end

	assign left_dec = (left_q != 8'd0) ? (left_q - 8'd1) : left_q;

	// next state for one byte
	always_comb begin
		fp_d     = fp_q;
		mp_d     = mp_q;
		left_d   = left_q;
		cnt_d    = cnt_q;
		data_hit = 1'b0;
		unique case (fp_q)
			FP_TYPE: begin
				fp_d = FP_LEN;
				if (mp_q == MP_SEARCH && byte_s1 == wanted_q) begin
					mp_d = MP_RUN;
				end else if (mp_q == MP_RUN && byte_s1 != wanted_q) begin
					mp_d = MP_DONE;
				end
			end
			FP_LEN: begin
				left_d = byte_s1;
				fp_d   = (byte_s1 != 8'd0) ? FP_VALUE : FP_TYPE;
			end
			FP_VALUE: begin
				data_hit = (mp_q == MP_RUN);
				if (data_hit && cnt_q != '1) begin
					cnt_d = cnt_q + LENGTH_BITS'(1);
				end
				left_d = left_dec;
				if (left_dec == 8'd0) begin
					fp_d = FP_TYPE;
				end
			end
			default: begin
				fp_d = FP_TYPE;
			end
		endcase
	end

	// state registers; a message end returns to the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q   <= FP_TYPE;
			mp_q   <= MP_SEARCH;
			left_q <= '0;
			cnt_q  <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				fp_q   <= FP_TYPE;
				mp_q   <= MP_SEARCH;
				left_q <= '0;
				cnt_q  <= '0;
			end else begin
				fp_q   <= fp_d;
				mp_q   <= mp_d;
				left_q <= left_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	// result words: {truncated, merged_len, found, data_byte, is_summary}
	assign data_res = {1'b0, LENGTH_BITS'(0), 1'b0, byte_s1, 1'b0};
	assign summ_res = {(fp_d != FP_TYPE), cnt_d, (mp_d != MP_SEARCH), 8'd0, 1'b1};

	assign push.first  = valid_s1 & (data_hit | last_s1);
	assign push.second = valid_s1 & data_hit & last_s1;
	assign res0        = data_hit ? data_res : summ_res;
	assign res1        = summ_res;

endmodule

/* design/tlv8x_result_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on tlv8x_pkg and tlv8_item_extractor_defines.svh.
`include "tlv8_item_extractor_defines.svh"
module tlv8x_result_fifo #(
	parameter int unsigned W = 27
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tlv8x_pkg::push_t push,
	input  logic [W-1:0]     din0,
	input  logic [W-1:0]     din1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [W-1:0]     out_data
);
	import tlv8x_pkg::*;

	logic [W-1:0]     mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q, n_push;
	logic             pop;
	logic [CNT_W:0]   fill_chk;

	assign n_push    = CNT_W'(push.first) + CNT_W'(push.second);
	assign out_valid = (count_q != '0);
	assign pop       = out_valid & out_ready;
	assign out_data  = mem_q[rd_ptr_q];
	assign room      = (count_q <= CNT_W'(ROOM_MAX));
	assign fill_chk  = {1'b0, count_q} + {1'b0, n_push};

	// storage: second push goes to the slot after the first
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (push.second) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= din1;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + n_push - CNT_W'(pop);
		end
	end

	`TLV8X_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(FIFO_DEPTH), "queue count over depth")
	`TLV8X_ASSERT(a_second_needs_first, clk, arst_n, push.second |-> push.first, "second push alone")
	`TLV8X_ASSERT_NEVER(a_no_overflow, clk, arst_n, fill_chk > (CNT_W+1)'(FIFO_DEPTH), "queue overflow")

endmodule

/* design/tlv8_item_extractor.sv */
// TLV8 item extractor top level.
// Depends on tlv8x_pkg, tlv8x_parser and tlv8x_result_fifo.
//
// Usage:
//   Message bytes enter on the s_axis channel, one per transfer; s_axis_tlast
//   marks the final byte of a message. The value bytes of the first run of
//   items of type wanted_type (set through cfg_we / cfg_wdata while idle)
//   leave on m_axis as data results (m_axis_tuser = 0), and each message ends
//   with one summary result (m_axis_tuser = 1) carrying found, the merged value
//   length (saturating) and a truncation flag.
//   Each byte transfer is registered at the input and its results are then written
//   into the result queue; a summary behind a data result of the same byte follows it.
//   Throughput: one byte per cycle while s_axis_tready is high; a byte yields at most
//   two results, which drain one per cycle while m_axis_tready is high, through an
//   eight-entry result queue. s_axis_tready drops once the queue holds more than four
//   results, so a stalled receiver backs up the input without losing anything.
//   Reset clears the configured type to 0, the message state and the queue;
//   after every final byte the parser's message state returns to reset by itself.
module tlv8_item_extractor #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] in_byte
	input  logic               s_axis_tlast,   // in_last
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [((LENGTH_BITS + 10 + 7) / 8) * 8 - 1:0] m_axis_tdata,
	                                           // data_byte, found, merged_len, truncated
	output logic               m_axis_tuser    // is_summary
);
	import tlv8x_pkg::*;

	localparam int unsigned RES_W   = LENGTH_BITS + 11;
	localparam int unsigned TDATA_W = ((LENGTH_BITS + 10 + 7) / 8) * 8;

	logic             valid_s1, last_s1;
	logic [7:0]       byte_s1;
	push_t            push;
	logic [RES_W-1:0] res0, res1, res_out;
	logic             room;

	assign s_axis_tready = room;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_axis_tvalid & s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid & s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	tlv8x_parser #(
		.LENGTH_BITS(LENGTH_BITS),
		.RES_W      (RES_W)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1),
		.push     (push),
		.res0     (res0),
		.res1     (res1)
	);

	tlv8x_result_fifo #(
		.W(RES_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din0     (res0),
		.din1     (res1),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (res_out)
	);

	// result word {truncated, merged_len, found, data_byte, is_summary}
	assign m_axis_tuser = res_out[0];
	assign m_axis_tdata = TDATA_W'(res_out[RES_W-1:1]);

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for tlv8_item_extractor: byte stream in, value bytes and summary out.
// Depends on tlv8x_pkg and the tlv8_item_extractor RTL; a built-in predictor checks each result.
module tb;
	import tlv8x_pkg::*;

	localparam int unsigned LEN_W   = 16;
	// data_byte, found, merged_len, truncated packed from bit 0, padded to whole bytes
	localparam int unsigned TDATA_W = ((8 + 1 + LEN_W + 1 + 7) / 8) * 8;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} msg_byte_t;

	typedef struct packed {
		logic             is_summary;
		logic [7:0]       data_byte;
		logic             found;
		logic [LEN_W-1:0] merged_len;
		logic             truncated;
	} tlv_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [7:0]         cfg_wdata = 8'h00;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic               s_axis_tlast = 1'b0;    // in_last
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;           // data_byte, found, merged_len, truncated
	logic               m_axis_tuser;           // is_summary

	// bytes waiting to be driven, results waiting to be seen
	msg_byte_t   pending_bytes[$];
	tlv_result_t expected_results[$];
	int          bytes_queued = 0;
	int          bytes_taken = 0;
	int          errors = 0;
	logic        took_byte = 1'b0;
	bit          steady = 1'b0;

	// predictor copy of the register and message state
	logic [7:0]       match_type = 8'h00;
	field_phase_t     parse_pos = FP_TYPE;
	match_phase_t     run_state = MP_SEARCH;
	logic [7:0]       value_left = 8'h00;
	logic [LEN_W-1:0] run_bytes = '0;

	tlv8_item_extractor #(
		.LENGTH_BITS(LEN_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parse one accepted byte and queue the results it causes
	task automatic decode_byte(input logic [7:0] b, input logic last);
		tlv_result_t r;
		case (parse_pos)
			FP_TYPE: begin
				if (run_state == MP_SEARCH && b == match_type)
					run_state = MP_RUN;
				else if (run_state == MP_RUN && b != match_type)
					run_state = MP_DONE;
				parse_pos = FP_LEN;
			end
			FP_LEN: begin
				value_left = b;
				parse_pos = (b != 8'h00) ? FP_VALUE : FP_TYPE;
			end
			default: begin
				if (run_state == MP_RUN) begin
					r = '0;
					r.data_byte = b;
					expected_results.push_back(r);
					if (run_bytes != {LEN_W{1'b1}})
						run_bytes = run_bytes + 1'b1;
				end
				if (value_left != 8'h00)
					value_left = value_left - 8'h01;
				if (value_left == 8'h00)
					parse_pos = FP_TYPE;
			end
		endcase
		// end of message: summary, then back to the start state
		if (last) begin
			r = '0;
			r.is_summary = 1'b1;
			r.found = (run_state != MP_SEARCH);
			r.merged_len = run_bytes;
			r.truncated = (parse_pos != FP_TYPE);
			expected_results.push_back(r);
			parse_pos = FP_TYPE;
			run_state = MP_SEARCH;
			value_left = 8'h00;
			run_bytes = '0;
		end
	endtask

	task automatic note_mismatch(input string what);
		errors++;
		if (errors <= 10)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// input driver: a new byte only once the previous one was transferred
	always @(negedge clk) begin
		msg_byte_t nxt;
		if (arst_n && (!s_axis_tvalid || took_byte)) begin
			if (pending_bytes.size() > 0 && (steady || $urandom_range(0, 99) >= 33)) begin
				nxt = pending_bytes.pop_front();
				s_axis_tdata <= nxt.value;
				s_axis_tlast <= nxt.last;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver stalls
	always @(negedge clk) begin
		if (arst_n)
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
	end

	// monitor: predict on each byte transfer, check each result transfer
	always @(posedge clk) begin
		tlv_result_t exp_r;
		took_byte <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast);
				bytes_taken++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf("unexpected result tuser=%0b tdata=%h",
						m_axis_tuser, m_axis_tdata));
				end else begin
					exp_r = expected_results.pop_front();
					if (m_axis_tuser !== exp_r.is_summary
							|| m_axis_tdata[7:0] !== exp_r.data_byte
							|| m_axis_tdata[8] !== exp_r.found
							|| m_axis_tdata[8+LEN_W:9] !== exp_r.merged_len
							|| m_axis_tdata[9+LEN_W] !== exp_r.truncated
							|| m_axis_tdata[TDATA_W-1:10+LEN_W] !== '0)
						note_mismatch($sformatf(
							{"exp summ=%0b data=%h found=%0b len=%0d trunc=%0b, ",
							"got summ=%0b data=%h found=%0b len=%0d trunc=%0b pad=%h"},
							exp_r.is_summary, exp_r.data_byte, exp_r.found,
							exp_r.merged_len, exp_r.truncated,
							m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
							m_axis_tdata[8+LEN_W:9], m_axis_tdata[9+LEN_W],
							m_axis_tdata[TDATA_W-1:10+LEN_W]));
				end
			end
		end
	end

	task automatic push_item(input logic [7:0] b, input logic last);
		msg_byte_t m;
		m.value = b;
		m.last = last;
		pending_bytes.push_back(m);
		bytes_queued++;
	endtask

	task automatic push_run(input logic [7:0] bytes[$], input logic ends);
		for (int i = 0; i < bytes.size(); i++)
			push_item(bytes[i], ends && (i == bytes.size() - 1));
	endtask

	// one random message: mostly well-formed items, some cut short, some pure noise
	task automatic queue_message(input logic [7:0] want);
		logic [7:0] msg[$];
		int kind;
		int n_items;
		int len;
		int sel;
		int cut;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 12))
				msg.push_back(8'($urandom_range(0, 255)));
		end else begin
			n_items = $urandom_range(1, 5);
			for (int i = 0; i < n_items; i++) begin
				msg.push_back($urandom_range(0, 1) ? want : 8'($urandom_range(0, 255)));
				sel = $urandom_range(0, 99);
				if (sel < 85)
					len = $urandom_range(0, 8);
				else if (sel < 95)
					len = $urandom_range(9, 40);
				else
					len = $urandom_range(0, 255);
				msg.push_back(8'(len));
				repeat (len)
					msg.push_back(8'($urandom_range(0, 255)));
			end
			// broken message: ends inside a header or value
			if (kind < 25 && msg.size() > 1) begin
				cut = $urandom_range(1, msg.size() - 1);
				msg = msg[0:cut-1];
			end
		end
		push_run(msg, 1'b1);
	endtask

	// block idle: every byte taken, every result seen, pipeline flushed
	task automatic wait_drained();
		while (!(bytes_taken == bytes_queued && expected_results.size() == 0))
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_wanted(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		match_type = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stimulus sequence
	initial begin
		logic [7:0] dir_bytes[$];
		int start_count;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset type 0: fragments incl. zero-length one, run ended, later match ignored
		dir_bytes = {8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80,
			8'hFF, 8'h01, 8'h01, 8'h00, 8'h01, 8'h7F};
		push_run(dir_bytes, 1'b1);
		// matching type byte as last byte
		dir_bytes = {8'h00};
		push_run(dir_bytes, 1'b1);
		// other type cut off in its value
		dir_bytes = {8'h12, 8'h05, 8'h01, 8'h02};
		push_run(dir_bytes, 1'b1);
		// wanted item cut off in its value
		dir_bytes = {8'h00, 8'h03, 8'hAB};
		push_run(dir_bytes, 1'b1);
		// ends on a zero length byte
		dir_bytes = {8'h34, 8'h00};
		push_run(dir_bytes, 1'b1);

		// type changed in the middle of a message
		wait_drained();
		write_wanted(8'hFF);
		dir_bytes = {8'hFF, 8'h02, 8'h10};
		push_run(dir_bytes, 1'b0);
		wait_drained();
		write_wanted(8'h00);
		dir_bytes = {8'h20, 8'h00, 8'h01, 8'h30};
		push_run(dir_bytes, 1'b1);

		// random messages under several type settings
		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			case (ph)
				0: write_wanted(8'hFF);
				1: write_wanted(8'h00);
				default: write_wanted(8'($urandom_range(0, 255)));
			endcase
			steady = (ph == 2);
			start_count = bytes_queued;
			while (bytes_queued - start_count < 65)
				queue_message(match_type);
		end

		wait_drained();
		if (errors == 0 && expected_results.size() == 0)
			$display("tlv8_item_extractor verification clean");
		else
			$display("tlv8_item_extractor verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#10000000;
		$display("tlv8_item_extractor verification failed");
		$finish;
	end

endmodule
